@@ sv/fus_pkg.sv @@
// ----------------------------------------------------------------------------
// fus_pkg
// Shared types and codes of the firmware upgrade sequencer.
// ----------------------------------------------------------------------------
package fus_pkg;

    // Actions carried by an input word.
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_ACK     = 2'd2;
    localparam logic [1:0] ACT_VERSION = 2'd3;

    // Commands issued toward the device.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_ERASE    = 3'd1;
    localparam logic [2:0] CMD_DATA     = 3'd2;
    localparam logic [2:0] CMD_CHECKSUM = 3'd3;
    localparam logic [2:0] CMD_RESET    = 3'd4;
    localparam logic [2:0] CMD_GETVER   = 3'd5;

    // Outcome codes reported when the sequence stops.
    localparam logic [2:0] OUT_NONE       = 3'd0;
    localparam logic [2:0] OUT_SUCCESS    = 3'd1;
    localparam logic [2:0] OUT_ERASE_TO   = 3'd2;
    localparam logic [2:0] OUT_DATA_TO    = 3'd3;
    localparam logic [2:0] OUT_CHECKSUM_TO = 3'd4;
    localparam logic [2:0] OUT_VERSION_TO = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_SIZE = 1'b0;
    localparam logic CFG_IMAGE_CRC  = 1'b1;

    // Protocol constants.
    localparam logic [7:0] ACK_OK      = 8'h01;
    localparam logic [7:0] MAX_RETRY   = 8'd10;
    localparam logic [6:0] TO_ERASE    = 7'd100;
    localparam logic [6:0] TO_DATA     = 7'd5;
    localparam logic [6:0] TO_CHECKSUM = 7'd50;
    localparam logic [6:0] TO_VERSION  = 7'd100;
    localparam logic [6:0] PCT_CAP     = 7'd99;
    localparam logic [6:0] PCT_DONE    = 7'd100;

    // Largest data chunk in bytes; the chunk length field is sized for it.
    localparam int unsigned CHUNK_BYTES = 256;

    // Quotient bits produced by the progress divider.
    localparam int unsigned QUOT_W = 8;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ERASE      = 4'd1,
        PH_WAIT_ERASE = 4'd2,
        PH_DATA       = 4'd3,
        PH_WAIT_DATA  = 4'd4,
        PH_CKSUM      = 4'd5,
        PH_WAIT_CKSUM = 4'd6,
        PH_GETVER     = 4'd7,
        PH_WAIT_VER   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_MUL  = 2'd1,
        CS_DIV  = 2'd2,
        CS_FIN  = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ack_code;
    } req_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [23:0] cmd_value;
        logic [8:0]  cmd_length;
        logic [6:0]  progress;
        logic        running;
        logic [2:0]  outcome;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;      // accept a word and advance the sequence
        logic load_step; // word result goes straight to the output register
        logic mul;       // form offset*100 and load the divider
        logic div;       // one restoring division step
        logic load_fin;  // finish progress and load the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the presented word completes a chunk with progress
        logic div_last;  // the current division step is the last one
    } dp_stat_t;

endpackage

@@ sv/firmware_upgrade_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// firmware_upgrade_sequencer_unit
// Host-side firmware upgrade sequencer: erase, chunked data, checksum, reset
// and version request, driven by tick, ack and version words.
// ----------------------------------------------------------------------------
// Usage. Each word on the req channel (start, tick, ack or version received)
// yields exactly one word on the rsp channel carrying the command to send to
// the device, its value and length, the progress percent, the running flag
// and an outcome code that is nonzero only on the word that ends a run.
// Both channels use valid/ready; a word moves when both are high.
// The user must write image size and CRC through the cfg port while the block
// is idle; the block does not enforce it. Writing the size also reloads the
// remaining byte count. Most words are taken one per cycle while the receiver
// keeps up, each with a registered result valid in the cycle after acceptance.
// A tick acknowledging a data chunk of a nonzero image computes progress as
// offset*100/size via a restoring divider giving one quotient bit per cycle;
// that word passes accept, multiply, 8 division steps and load, blocking
// others. After reset the sequence is idle, all counters are zero and no
// result is pending. When the receiver stalls, the result waits in the output
// register and a new word is accepted in the same cycle the old one is taken.
// ----------------------------------------------------------------------------
module firmware_upgrade_sequencer_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fus_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fus_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [23:0]   cfg_data
);

    // Command and status between the controller and the datapath.
    fus_pkg::dp_cmd_t  dp_cmd;
    fus_pkg::dp_stat_t dp_stat;

    // The controller owns the handshakes and steps the divider.
    fus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // The datapath holds the sequence state, configuration and result word.
    fus_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

@@ sv/fus_ctrl.sv @@
// ----------------------------------------------------------------------------
// fus_ctrl
// Handshake and division sequencing controller of the upgrade sequencer.
// ----------------------------------------------------------------------------
module fus_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  fus_pkg::dp_stat_t  stat,
    output fus_pkg::dp_cmd_t   cmd
);

    fus_pkg::ctl_state_t state_reg;
    fus_pkg::ctl_state_t state_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                slot_free;

    // The output register may be refilled when empty or draining this cycle.
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fus_pkg::CS_IDLE:
            begin
                if (req_valid && slot_free && stat.need_div)
                begin
                    state_next = fus_pkg::CS_MUL;
                end
            end
            fus_pkg::CS_MUL:
            begin
                state_next = fus_pkg::CS_DIV;
            end
            fus_pkg::CS_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = fus_pkg::CS_FIN;
                end
            end
            fus_pkg::CS_FIN:
            begin
                if (slot_free)
                begin
                    state_next = fus_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = fus_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            fus_pkg::CS_IDLE:
            begin
                req_ready     = slot_free;
                cmd.step      = req_valid && slot_free;
                cmd.load_step = req_valid && slot_free && !stat.need_div;
            end
            fus_pkg::CS_MUL:
            begin
                cmd.mul = 1'b1;
            end
            fus_pkg::CS_DIV:
            begin
                cmd.div = 1'b1;
            end
            fus_pkg::CS_FIN:
            begin
                cmd.load_fin = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_step || cmd.load_fin)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fus_pkg::CS_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ sv/fus_dp.sv @@
// ----------------------------------------------------------------------------
// fus_dp
// Sequencer state, command generation and iterative progress divider.
// ----------------------------------------------------------------------------
module fus_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [23:0]       cfg_data,
    input  fus_pkg::req_t     req,
    output fus_pkg::rsp_t     rsp,
    input  fus_pkg::dp_cmd_t  cmd,
    output fus_pkg::dp_stat_t stat
);

    localparam int unsigned NUM_W = 31;
    localparam int unsigned CNT_W = $clog2(fus_pkg::QUOT_W);
    localparam logic [23:0] CHUNK = 24'(fus_pkg::CHUNK_BYTES);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(fus_pkg::QUOT_W - 1);

    logic [23:0]      image_size_reg;
    logic [15:0]      image_crc_reg;
    fus_pkg::phase_t  phase_reg, phase_next;
    logic             active_reg, active_next;
    logic [7:0]       ack_reg, ack_next;
    logic             ver_reg, ver_next;
    logic [6:0]       wait_reg, wait_next;
    logic [7:0]       retry_reg, retry_next;
    logic [23:0]      offset_reg, offset_next;
    logic [23:0]      left_reg, left_next;
    logic [6:0]       prog_reg, prog_next;

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] dsr_reg;
    logic [fus_pkg::QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    fus_pkg::rsp_t    rsp_reg;

    fus_pkg::rsp_t    res;
    fus_pkg::rsp_t    fin_rsp;
    logic [6:0]       tick_limit;
    logic [6:0]       wait_inc;
    logic             expired;
    logic [7:0]       retry_inc;
    logic             exhausted;
    logic             tick_active;
    logic             rem_ge;
    logic [6:0]       pct;

    assign tick_active = (req.action == fus_pkg::ACT_TICK) && active_reg;

    always_comb
    begin
        case (phase_reg)
            fus_pkg::PH_WAIT_ERASE: tick_limit = fus_pkg::TO_ERASE;
            fus_pkg::PH_WAIT_DATA:  tick_limit = fus_pkg::TO_DATA;
            fus_pkg::PH_WAIT_CKSUM: tick_limit = fus_pkg::TO_CHECKSUM;
            default:                tick_limit = fus_pkg::TO_VERSION;
        endcase
    end

    assign wait_inc  = wait_reg + 7'd1;
    assign expired   = wait_inc >= tick_limit;
    assign retry_inc = (retry_reg == 8'hFF) ? retry_reg : retry_reg + 8'd1;
    assign exhausted = retry_inc >= fus_pkg::MAX_RETRY;

    assign stat.need_div = tick_active && (phase_reg == fus_pkg::PH_WAIT_DATA)
                           && (ack_reg == fus_pkg::ACK_OK) && (image_size_reg != 24'd0);
    assign stat.div_last = (cnt_reg == '0);

    // One step of the sequence for the presented word.
    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        ack_next    = ack_reg;
        ver_next    = ver_reg;
        wait_next   = wait_reg;
        retry_next  = retry_reg;
        offset_next = offset_reg;
        left_next   = left_reg;
        prog_next   = prog_reg;
        res         = '0;
        if (cmd.step)
        begin
            case (req.action)
                fus_pkg::ACT_START:
                begin
                    phase_next  = fus_pkg::PH_ERASE;
                    prog_next   = 7'd0;
                    active_next = 1'b1;
                end
                fus_pkg::ACT_ACK:
                begin
                    ack_next = req.ack_code;
                end
                fus_pkg::ACT_VERSION:
                begin
                    ver_next = 1'b1;
                end
                default:
                begin
                    if (active_reg)
                    begin
                        case (phase_reg)
                            fus_pkg::PH_ERASE:
                            begin
                                res.command   = fus_pkg::CMD_ERASE;
                                res.cmd_value = left_reg;
                                wait_next     = 7'd0;
                                phase_next    = fus_pkg::PH_WAIT_ERASE;
                            end
                            fus_pkg::PH_WAIT_ERASE:
                            begin
                                if (ack_reg == fus_pkg::ACK_OK)
                                begin
                                    ack_next    = 8'd0;
                                    wait_next   = 7'd0;
                                    offset_next = 24'd0;
                                    phase_next  = fus_pkg::PH_DATA;
                                end
                                else
                                begin
                                    wait_next = expired ? 7'd0 : wait_inc;
                                    if (expired)
                                    begin
                                        phase_next  = fus_pkg::PH_ERASE;
                                        active_next = 1'b0;
                                        res.outcome = fus_pkg::OUT_ERASE_TO;
                                    end
                                end
                            end
                            fus_pkg::PH_DATA:
                            begin
                                res.command    = fus_pkg::CMD_DATA;
                                res.cmd_value  = offset_reg;
                                res.cmd_length = (left_reg > CHUNK) ? CHUNK[8:0] : left_reg[8:0];
                                phase_next     = fus_pkg::PH_WAIT_DATA;
                            end
                            fus_pkg::PH_WAIT_DATA:
                            begin
                                if (ack_reg == fus_pkg::ACK_OK)
                                begin
                                    ack_next   = 8'd0;
                                    wait_next  = 7'd0;
                                    retry_next = 8'd0;
                                    if (left_reg > CHUNK)
                                    begin
                                        left_next   = left_reg - CHUNK;
                                        offset_next = offset_reg + CHUNK;
                                        phase_next  = fus_pkg::PH_DATA;
                                    end
                                    else
                                    begin
                                        offset_next = offset_reg + left_reg;
                                        left_next   = 24'd0;
                                        phase_next  = fus_pkg::PH_CKSUM;
                                    end
                                    // A nonzero size gets its percentage from the divider.
                                    if (image_size_reg == 24'd0)
                                    begin
                                        prog_next = 7'd0;
                                    end
                                end
                                else
                                begin
                                    wait_next = expired ? 7'd0 : wait_inc;
                                    if (expired)
                                    begin
                                        phase_next = fus_pkg::PH_DATA;
                                        retry_next = retry_inc;
                                        if (exhausted)
                                        begin
                                            phase_next  = fus_pkg::PH_ERASE;
                                            active_next = 1'b0;
                                            res.outcome = fus_pkg::OUT_DATA_TO;
                                        end
                                    end
                                end
                            end
                            fus_pkg::PH_CKSUM:
                            begin
                                left_next     = image_size_reg;
                                res.command   = fus_pkg::CMD_CHECKSUM;
                                res.cmd_value = {8'd0, image_crc_reg};
                                phase_next    = fus_pkg::PH_WAIT_CKSUM;
                            end
                            fus_pkg::PH_WAIT_CKSUM:
                            begin
                                if (ack_reg == fus_pkg::ACK_OK)
                                begin
                                    wait_next   = 7'd0;
                                    retry_next  = 8'd0;
                                    res.command = fus_pkg::CMD_RESET;
                                    phase_next  = fus_pkg::PH_GETVER;
                                end
                                else
                                begin
                                    wait_next = expired ? 7'd0 : wait_inc;
                                    if (expired)
                                    begin
                                        phase_next = fus_pkg::PH_CKSUM;
                                        retry_next = retry_inc;
                                        if (exhausted)
                                        begin
                                            phase_next  = fus_pkg::PH_ERASE;
                                            active_next = 1'b0;
                                            res.outcome = fus_pkg::OUT_CHECKSUM_TO;
                                        end
                                    end
                                end
                            end
                            fus_pkg::PH_GETVER:
                            begin
                                ver_next    = 1'b0;
                                res.command = fus_pkg::CMD_GETVER;
                                phase_next  = fus_pkg::PH_WAIT_VER;
                            end
                            fus_pkg::PH_WAIT_VER:
                            begin
                                if (ver_reg)
                                begin
                                    phase_next  = fus_pkg::PH_IDLE;
                                    prog_next   = fus_pkg::PCT_DONE;
                                    active_next = 1'b0;
                                    res.outcome = fus_pkg::OUT_SUCCESS;
                                end
                                else
                                begin
                                    wait_next = expired ? 7'd0 : wait_inc;
                                    if (expired)
                                    begin
                                        phase_next = fus_pkg::PH_GETVER;
                                        retry_next = retry_inc;
                                        if (exhausted)
                                        begin
                                            phase_next  = fus_pkg::PH_ERASE;
                                            active_next = 1'b0;
                                            res.outcome = fus_pkg::OUT_VERSION_TO;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            endcase
        end
        res.progress = prog_next;
        res.running  = active_next;
    end

    // Restoring division step and the capped percentage.
    assign rem_ge = num_reg >= dsr_reg;
    assign pct    = (quot_reg >= fus_pkg::QUOT_W'(fus_pkg::PCT_DONE)) ? fus_pkg::PCT_CAP
                                                                        : quot_reg[6:0];

    // Result word of a chunk acknowledge whose progress came from the divider.
    always_comb
    begin
        fin_rsp          = '0;
        fin_rsp.command  = fus_pkg::CMD_NONE;
        fin_rsp.progress = pct;
        fin_rsp.running  = active_reg;
        fin_rsp.outcome  = fus_pkg::OUT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= 24'd0;
            image_crc_reg  <= 16'd0;
            phase_reg      <= fus_pkg::PH_IDLE;
            active_reg     <= 1'b0;
            ack_reg        <= 8'd0;
            ver_reg        <= 1'b0;
            wait_reg       <= 7'd0;
            retry_reg      <= 8'd0;
            offset_reg     <= 24'd0;
            left_reg       <= 24'd0;
            prog_reg       <= 7'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            ack_reg    <= ack_next;
            ver_reg    <= ver_next;
            wait_reg   <= wait_next;
            retry_reg  <= retry_next;
            offset_reg <= offset_next;
            prog_reg   <= cmd.load_fin ? pct : prog_next;
            // Writing the image size also reloads the remaining byte count.
            if (cfg_we && (cfg_index == fus_pkg::CFG_IMAGE_SIZE))
            begin
                left_reg <= cfg_data;
            end
            else
            begin
                left_reg <= left_next;
            end
            if (cmd.mul)
            begin
                cnt_reg <= CNT_TOP;
            end
            else if (cmd.div)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fus_pkg::CFG_IMAGE_SIZE:
                    begin
                        image_size_reg <= cfg_data;
                    end
                    default:
                    begin
                        image_crc_reg <= cfg_data[15:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            // offset * 100 as offset*64 + offset*32 + offset*4.
            num_reg  <= {1'b0, offset_reg, 6'd0} + {2'b0, offset_reg, 5'd0}
                        + {5'b0, offset_reg, 2'd0};
            dsr_reg  <= {image_size_reg, 7'd0};
            quot_reg <= '0;
        end
        else if (cmd.div)
        begin
            if (rem_ge)
            begin
                num_reg <= num_reg - dsr_reg;
            end
            dsr_reg  <= dsr_reg >> 1;
            quot_reg <= {quot_reg[fus_pkg::QUOT_W-2:0], rem_ge};
        end
        if (cmd.load_step)
        begin
            rsp_reg <= res;
        end
        else if (cmd.load_fin)
        begin
            rsp_reg <= fin_rsp;
        end
    end

    assign rsp = rsp_reg;

endmodule
